@@ rtl/hp_pkg.sv @@
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hp_pkg;

    localparam int HP_CAPACITY = 1024;
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 11;

    // Request codes carried in req_type. The unused code behaves as a peek.
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Value reported when there is no entry to show.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    // Operand selection for the shared comparator.
    typedef logic [1:0] cmp_sel_t;
    localparam cmp_sel_t CMP_UP       = 2'd0; // carried value < parent
    localparam cmp_sel_t CMP_CHILDREN = 2'd1; // right child < left child
    localparam cmp_sel_t CMP_DOWN     = 2'd2; // smaller child < carried value

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } hp_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] min_after;
        logic [ENTRY_W-1:0]       entry_count;
        logic                     is_empty;
        logic [1:0]               status;
    } hp_rsp_t;

endpackage

`default_nettype wire

@@ rtl/hp_cmp.sv @@
// Shared signed comparator of the heap sequencer, with its operand select.
// Depends on hp_pkg.
`default_nettype none

module hp_cmp (
    input  hp_pkg::cmp_sel_t                 sel,
    input  logic signed [hp_pkg::DATA_W-1:0] carry_val,
    input  logic signed [hp_pkg::DATA_W-1:0] mem_val,
    input  logic signed [hp_pkg::DATA_W-1:0] child_val,
    output logic                             less
);
    import hp_pkg::*;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;

    always_comb begin
        unique case (sel)
            CMP_UP: begin
                op_a = carry_val;
                op_b = mem_val;
            end
            CMP_CHILDREN: begin
                op_a = mem_val;
                op_b = child_val;
            end
            CMP_DOWN: begin
                op_a = child_val;
                op_b = carry_val;
            end
            default: begin
                op_a = carry_val;
                op_b = carry_val;
            end
        endcase
    end

    assign less = (op_a < op_b);

endmodule

`default_nettype wire

@@ rtl/binary_min_heap_priority_queue_core.sv @@
// Top level of the binary min-heap priority queue: sequencer, heap memory,
// root copy and result register. Depends on hp_pkg and hp_cmp.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_data (hp_pkg::hp_req_t)
//   m_        out        m_valid / m_ready  m_data (hp_pkg::hp_rsp_t)
//
// Peek, empty extract and full insert go from the idle state straight to the final
// state. Insert and extract walk the value up or down the heap; each level that
// the value moves costs one read of the heap memory and one pass through the
// shared comparator (two reads and two passes when both children are present
// on the way down).
// Reset (aresetn low, synchronous) empties the heap; memory contents are not
// cleared because only entries below the count are ever read.
// s_ready is high only while the sequencer is idle; a result waiting on
// m_ready holds the sequencer in its final state until the output register frees.
`default_nettype none

module binary_min_heap_priority_queue_core #(
    parameter int CAPACITY = hp_pkg::HP_CAPACITY
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hp_pkg::hp_req_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output hp_pkg::hp_rsp_t m_data
);
    import hp_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_RD   = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_DN_LAST = 4'd3;
    localparam logic [3:0] ST_DN_CHK  = 4'd4;
    localparam logic [3:0] ST_DN_L    = 4'd5;
    localparam logic [3:0] ST_DN_R    = 4'd6;
    localparam logic [3:0] ST_DN_CMP  = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    // Heap storage: one-indexed position p lives at address p-1.
    logic signed [DATA_W-1:0] heap_mem [CAPACITY];

    logic [3:0]               state_reg,     state_next;
    logic [CNT_W-1:0]         count_reg,     count_next;
    logic [CNT_W-1:0]         pos_reg,       pos_next;
    logic [CNT_W-1:0]         child_pos_reg, child_pos_next;
    logic signed [DATA_W-1:0] val_reg,       val_next;
    logic signed [DATA_W-1:0] child_reg,     child_next;
    logic signed [DATA_W-1:0] removed_reg,   removed_next;
    logic [1:0]               status_reg,    status_next;
    logic signed [DATA_W-1:0] root_reg,      root_next;
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     m_valid_reg,   m_valid_next;
    hp_rsp_t                  m_data_reg,    m_data_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;

    cmp_sel_t                 cmp_sel;
    logic                     cmp_less;

    logic [CNT_W:0]           left_pos;   // 2*pos, may exceed the count
    logic [CNT_W:0]           right_pos;  // 2*pos+1
    logic [CNT_W-1:0]         parent_pos;
    logic                     accept;

    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign parent_pos = pos_reg >> 1;
    assign accept     = s_valid && s_ready;

    hp_cmp u_cmp (
        .sel       (cmp_sel),
        .carry_val (val_reg),
        .mem_val   (rdata_reg),
        .child_val (child_reg),
        .less      (cmp_less)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        child_pos_next = child_pos_reg;
        val_next       = val_reg;
        child_next     = child_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(pos_reg - 1'b1);
        mem_wdata      = val_reg;
        mem_raddr      = ADDR_W'(pos_reg - 1'b1);
        cmp_sel        = CMP_UP;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    removed_next = '0;
                    status_next  = STAT_OK;
                    if (s_data.req_type == REQ_INSERT) begin
                        if (count_reg == FULL_COUNT) begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            count_next = count_reg + 1'b1;
                            pos_next   = count_reg + 1'b1;
                            val_next   = s_data.value;
                            state_next = ST_UP_RD;
                        end
                    end else if (count_reg == '0) begin
                        removed_next = EMPTY_VALUE;
                        status_next  = STAT_EMPTY;
                        state_next   = ST_DONE;
                    end else begin
                        removed_next = root_reg;
                        if (s_data.req_type == REQ_EXTRACT) begin
                            // Fetch the last entry; it refills the root.
                            mem_raddr  = ADDR_W'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = ST_DN_LAST;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == CNT_W'(1)) begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    mem_raddr  = ADDR_W'(parent_pos - 1'b1);
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                // The parent moves down into the hole when the new value is smaller.
                cmp_sel = CMP_UP;
                mem_we  = 1'b1;
                if (cmp_less) begin
                    mem_wdata  = rdata_reg;
                    pos_next   = parent_pos;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DN_LAST: begin
                val_next   = rdata_reg;
                pos_next   = CNT_W'(1);
                state_next = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (left_pos > {1'b0, count_reg}) begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    mem_raddr  = ADDR_W'(left_pos - 1'b1);
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L: begin
                child_next     = rdata_reg;
                child_pos_next = CNT_W'(left_pos);
                if (right_pos <= {1'b0, count_reg}) begin
                    mem_raddr  = ADDR_W'(left_pos);
                    state_next = ST_DN_R;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_R: begin
                // Right child wins only when strictly smaller.
                cmp_sel = CMP_CHILDREN;
                if (cmp_less) begin
                    child_next     = rdata_reg;
                    child_pos_next = CNT_W'(right_pos);
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                cmp_sel = CMP_DOWN;
                mem_we  = 1'b1;
                if (cmp_less) begin
                    mem_wdata  = child_reg;
                    pos_next   = child_pos_reg;
                    state_next = ST_DN_CHK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.removed_value = removed_reg;
                    m_data_next.min_after     = (count_reg == '0) ? EMPTY_VALUE : root_reg;
                    m_data_next.entry_count   = ENTRY_W'(count_reg);
                    m_data_next.is_empty      = (count_reg == '0);
                    m_data_next.status        = status_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The root is mirrored in a register so peeks and results need no read.
    always_comb begin
        root_next = root_reg;
        if (mem_we && (mem_waddr == '0)) begin
            root_next = mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= heap_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        child_pos_reg <= child_pos_next;
        val_reg       <= val_next;
        child_reg     <= child_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        root_reg      <= root_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/hp_chk.sv @@
// Port-level checker for the heap priority queue and its bind to the top.
// Depends on hp_pkg and binary_min_heap_priority_queue_core.
`default_nettype none

module hp_chk #(
    parameter int CAPACITY = hp_pkg::HP_CAPACITY
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input hp_pkg::hp_req_t s_data,
    input logic            m_valid,
    input logic            m_ready,
    input hp_pkg::hp_rsp_t m_data
);
    import hp_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Every request leaves the idle state, so the block is busy right after a transfer.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // An empty heap reports a zero count and the empty marker as its minimum.
    a_empty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |->
            (m_data.entry_count == '0) && (m_data.min_after == EMPTY_VALUE))
        else $error("empty result inconsistent");

    // A rejected insert only happens at capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_FULL) |->
            (m_data.entry_count == ENTRY_W'(CNT_W'(CAPACITY))) && !m_data.is_empty)
        else $error("full status below capacity");

endmodule

bind binary_min_heap_priority_queue_core hp_chk #(
    .CAPACITY (CAPACITY)
) u_hp_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
